// ===== rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere intersection package
// Widths, register indexes and the types shared by the front end, the job
// queue and the back end.
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int COORD_W     = 32;
   localparam int RAD_W       = 31;
   localparam int OC_W        = COORD_W + 1;
   localparam int A_W         = 2 * COORD_W;
   localparam int H_W         = 67;
   localparam int K_W         = 67;
   localparam int PROD_W      = 130;
   localparam int DISC_W      = 132;
   localparam int SQ_STEPS    = DISC_W / 2;
   localparam int ROOT_W      = SQ_STEPS;
   localparam int NUM_W       = 68;
   localparam int FRAC_W      = 16;
   localparam int DIST_W      = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_CENTER_Z = 2'd2,
      CSR_RADIUS   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic        [RAD_W-1:0]   radius;
   } sphere_type;

   typedef struct packed {
      logic                  miss;
      logic                  near;
      logic signed [H_W-1:0] negh;
      logic [A_W-1:0]        a;
      logic [DISC_W-1:0]     disc;
   } ray_job_type;

endpackage

// ===== rtl/rsi_front.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere intersection front end
// Seven-stage pipeline that forms the quadratic terms and the discriminant
// and classifies each ray as miss, near-root hit or far-root hit.
// ----------------------------------------------------------------------------
module rsi_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_origin_x,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_origin_y,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_origin_z,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_dir_x,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_dir_y,
   input  logic signed [rsi_pkg::COORD_W-1:0] req_dir_z,
   input  rsi_pkg::sphere_type                sphere,
   output logic                               job_valid,
   input  logic                               job_ready,
   output rsi_pkg::ray_job_type               job
);

   localparam int CW = rsi_pkg::COORD_W;
   localparam int OW = rsi_pkg::OC_W;
   localparam int AW = rsi_pkg::A_W;
   localparam int HW = rsi_pkg::H_W;
   localparam int KW = rsi_pkg::K_W;
   localparam int PW = rsi_pkg::PROD_W;
   localparam int DW = rsi_pkg::DISC_W;
   localparam int RW = rsi_pkg::RAD_W;
   localparam int HM_W = HW - 2;
   localparam int KM_W = KW - 1;
   localparam int HLO_W = 33;
   localparam int KLO_W = 33;
   localparam int ALO_W = AW / 2;

   logic adv;
   logic [7:1] v_ff;

   // stage 1
   logic signed [OW-1:0] oc_ff [3];
   logic signed [CW-1:0] d_ff  [3];
   logic [RW-1:0]        r_ff;
   // stage 2
   logic signed [2*CW-1:0] dsq_in  [3];
   logic signed [OW+CW-1:0] hp_in  [3];
   logic signed [2*OW-1:0] ocsq_in [3];
   logic [2*CW-2:0]        dsq_ff  [3];
   logic signed [OW+CW-1:0] hp_ff  [3];
   logic [2*CW-1:0]        ocsq_ff [3];
   logic [2*RW-1:0]        rsq_ff;
   // stage 3
   logic [AW-1:0]        a_in, a3_ff;
   logic signed [HW-1:0] h_in, h3_ff;
   logic [KW-1:0]        k_in;
   logic signed [KW-1:0] k3_ff;
   // stage 4
   logic [HW-1:0]        habs_in;
   logic [KW-1:0]        kabs_in;
   logic [HM_W-1:0]      hm_ff;
   logic [KM_W-1:0]      km_ff;
   logic [AW-1:0]        a4_ff, a5_ff, a6_ff;
   logic signed [HW-1:0] negh4_ff, negh5_ff, negh6_ff;
   logic                 hnp4_ff, kneg4_ff, kzero4_ff, azero4_ff;
   logic                 hnp5_ff, kneg5_ff, kzero5_ff, azero5_ff;
   logic                 hnp6_ff, kneg6_ff, kzero6_ff, azero6_ff;
   // stage 5
   logic [63:0]          p_hh_ff;
   logic [64:0]          p_hx_ff;
   logic [65:0]          p_ll_ff;
   logic [64:0]          p_akhh_ff, p_akhl_ff, p_aklh_ff, p_akll_ff;
   // stage 6
   logic [PW-1:0]        hsq_in, ak_in, hsq_ff, ak_ff;
   // stage 7
   logic [DW-1:0]        disc_in;
   logic                 near_in, far_in, miss_in;
   rsi_pkg::ray_job_type job_ff;

   assign adv       = !v_ff[7] || job_ready;
   assign req_ready = adv;
   assign job_valid = v_ff[7];
   assign job       = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[6:1], req_valid};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dsq_in[i]  = d_ff[i] * d_ff[i];
         hp_in[i]   = oc_ff[i] * d_ff[i];
         ocsq_in[i] = oc_ff[i] * oc_ff[i];
      end
      a_in = AW'(dsq_ff[0]) + AW'(dsq_ff[1]) + AW'(dsq_ff[2]);
      h_in = HW'(hp_ff[0]) + HW'(hp_ff[1]) + HW'(hp_ff[2]);
      k_in = KW'(ocsq_ff[0]) + KW'(ocsq_ff[1]) + KW'(ocsq_ff[2]) - KW'(rsq_ff);
      habs_in = h3_ff[HW-1] ? -h3_ff : h3_ff;
      kabs_in = k3_ff[KW-1] ? -k3_ff : k3_ff;
      hsq_in = (PW'(p_hh_ff) << (2 * HLO_W)) + (PW'(p_hx_ff) << (HLO_W + 1))
             + PW'(p_ll_ff);
      ak_in  = (PW'(p_akhh_ff) << (ALO_W + KLO_W)) + (PW'(p_akhl_ff) << ALO_W)
             + (PW'(p_aklh_ff) << KLO_W) + PW'(p_akll_ff);
      disc_in = kneg6_ff ? DW'(hsq_ff) + DW'(ak_ff) : DW'(hsq_ff) - DW'(ak_ff);
      near_in = hnp6_ff && !kneg6_ff;
      far_in  = hnp6_ff || kneg6_ff || kzero6_ff;
      miss_in = azero6_ff || disc_in[DW-1] || !(near_in || far_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oc_ff[0] <= OW'(req_origin_x) - OW'(sphere.center_x);
         oc_ff[1] <= OW'(req_origin_y) - OW'(sphere.center_y);
         oc_ff[2] <= OW'(req_origin_z) - OW'(sphere.center_z);
         d_ff[0]  <= req_dir_x;
         d_ff[1]  <= req_dir_y;
         d_ff[2]  <= req_dir_z;
         r_ff     <= sphere.radius;

         for (int i = 0; i < 3; i++) begin
            dsq_ff[i]  <= dsq_in[i][2*CW-2:0];
            hp_ff[i]   <= hp_in[i];
            ocsq_ff[i] <= ocsq_in[i][2*CW-1:0];
         end
         rsq_ff <= r_ff * r_ff;

         a3_ff <= a_in;
         h3_ff <= h_in;
         k3_ff <= $signed(k_in);

         hm_ff     <= habs_in[HM_W-1:0];
         km_ff     <= kabs_in[KM_W-1:0];
         a4_ff     <= a3_ff;
         negh4_ff  <= -h3_ff;
         hnp4_ff   <= h3_ff[HW-1] || (h3_ff == '0);
         kneg4_ff  <= k3_ff[KW-1];
         kzero4_ff <= (k3_ff == '0);
         azero4_ff <= (a3_ff == '0);

         p_hh_ff   <= hm_ff[HM_W-1:HLO_W] * hm_ff[HM_W-1:HLO_W];
         p_hx_ff   <= hm_ff[HM_W-1:HLO_W] * hm_ff[HLO_W-1:0];
         p_ll_ff   <= hm_ff[HLO_W-1:0] * hm_ff[HLO_W-1:0];
         p_akhh_ff <= a4_ff[AW-1:ALO_W] * km_ff[KM_W-1:KLO_W];
         p_akhl_ff <= a4_ff[AW-1:ALO_W] * km_ff[KLO_W-1:0];
         p_aklh_ff <= a4_ff[ALO_W-1:0] * km_ff[KM_W-1:KLO_W];
         p_akll_ff <= a4_ff[ALO_W-1:0] * km_ff[KLO_W-1:0];
         a5_ff     <= a4_ff;
         negh5_ff  <= negh4_ff;
         hnp5_ff   <= hnp4_ff;
         kneg5_ff  <= kneg4_ff;
         kzero5_ff <= kzero4_ff;
         azero5_ff <= azero4_ff;

         hsq_ff    <= hsq_in;
         ak_ff     <= ak_in;
         a6_ff     <= a5_ff;
         negh6_ff  <= negh5_ff;
         hnp6_ff   <= hnp5_ff;
         kneg6_ff  <= kneg5_ff;
         kzero6_ff <= kzero5_ff;
         azero6_ff <= azero5_ff;

         job_ff.miss <= miss_in;
         job_ff.near <= near_in;
         job_ff.negh <= negh6_ff;
         job_ff.a    <= a6_ff;
         job_ff.disc <= disc_in;
      end
   end

endmodule

// ===== rtl/rsi_queue.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere intersection job queue
// Small first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module rsi_queue #(
   parameter int DEPTH = rsi_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rsi_pkg::ray_job_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rsi_pkg::ray_job_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsi_pkg::ray_job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/rsi_back.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere intersection back end
// Pipelined square root of the discriminant, root selection and a pipelined
// restoring divider that scales the root to a Q16.16 distance.
// ----------------------------------------------------------------------------
module rsi_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   output logic                                job_ready,
   input  rsi_pkg::ray_job_type                job,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [rsi_pkg::DIST_W-1:0]          rsp_hit_distance
);

   localparam int DW = rsi_pkg::DISC_W;
   localparam int SQ = rsi_pkg::SQ_STEPS;
   localparam int HW = rsi_pkg::H_W;
   localparam int AW = rsi_pkg::A_W;
   localparam int NW = rsi_pkg::NUM_W;
   localparam int FW = rsi_pkg::FRAC_W;
   localparam int QW = rsi_pkg::DIST_W;
   localparam int RTW = rsi_pkg::ROOT_W;

   logic adv;

   logic                 sq_v_ff    [SQ+1];
   logic                 sq_miss_ff [SQ+1];
   logic                 sq_near_ff [SQ+1];
   logic signed [HW-1:0] sq_negh_ff [SQ+1];
   logic [AW-1:0]        sq_a_ff    [SQ+1];
   logic [DW-1:0]        sq_x_ff    [SQ+1];
   logic [DW-1:0]        sq_res_ff  [SQ+1];

   logic                 n_v_ff, n_miss_ff;
   logic [AW-1:0]        n_a_ff;
   logic signed [NW-1:0] num_in, num_ff;

   logic                 dv_v_ff   [QW+1];
   logic                 dv_hit_ff [QW+1];
   logic                 dv_sat_ff [QW+1];
   logic [AW-1:0]        dv_a_ff   [QW+1];
   logic [AW-1:0]        dv_rem_ff [QW+1];
   logic [QW-1:0]        dv_lo_ff  [QW+1];
   logic [QW-1:0]        dv_q_ff   [QW+1];

   logic                 rsp_valid_ff, rsp_hit_ff;
   logic [QW-1:0]        rsp_dist_in, rsp_dist_ff;

   assign adv              = !rsp_valid_ff || rsp_ready;
   assign job_ready        = adv;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_distance = rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_miss_ff[0] <= job.miss;
         sq_near_ff[0] <= job.near;
         sq_negh_ff[0] <= job.negh;
         sq_a_ff[0]    <= job.a;
         sq_x_ff[0]    <= job.disc;
         sq_res_ff[0]  <= '0;
      end
   end

   for (genvar g = 1; g <= SQ; g++) begin : g_sqrt
      localparam int SH = 2 * (SQ - g);
      logic [DW-1:0] bit_c, t_c, x_in, res_in;

      always_comb begin
         bit_c = DW'(1) << SH;
         t_c   = sq_res_ff[g-1] + bit_c;
         if (sq_x_ff[g-1] >= t_c) begin
            x_in   = sq_x_ff[g-1] - t_c;
            res_in = (sq_res_ff[g-1] >> 1) + bit_c;
         end else begin
            x_in   = sq_x_ff[g-1];
            res_in = sq_res_ff[g-1] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[g] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[g] <= sq_v_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_miss_ff[g] <= sq_miss_ff[g-1];
            sq_near_ff[g] <= sq_near_ff[g-1];
            sq_negh_ff[g] <= sq_negh_ff[g-1];
            sq_a_ff[g]    <= sq_a_ff[g-1];
            sq_x_ff[g]    <= x_in;
            sq_res_ff[g]  <= res_in;
         end
      end
   end

   assign num_in = sq_near_ff[SQ]
      ? NW'(sq_negh_ff[SQ]) - $signed(NW'(sq_res_ff[SQ][RTW-1:0]))
      : NW'(sq_negh_ff[SQ]) + $signed(NW'(sq_res_ff[SQ][RTW-1:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff     <= 1'b0;
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         n_v_ff     <= sq_v_ff[SQ];
         dv_v_ff[0] <= n_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_miss_ff <= sq_miss_ff[SQ];
         n_a_ff    <= sq_a_ff[SQ];
         num_ff    <= num_in;

         dv_hit_ff[0] <= !n_miss_ff;
         dv_sat_ff[0] <= (AW'(num_ff[NW-1:FW]) >= n_a_ff);
         dv_a_ff[0]   <= n_a_ff;
         dv_rem_ff[0] <= AW'(num_ff[NW-1:FW]);
         dv_lo_ff[0]  <= {num_ff[FW-1:0], {(QW-FW){1'b0}}};
         dv_q_ff[0]   <= '0;
      end
   end

   for (genvar g = 1; g <= QW; g++) begin : g_div
      localparam int IX = QW - g;
      logic [AW:0]   rem2_c, diff_c;
      logic          ge_c;
      logic [AW-1:0] rem_in;
      logic [QW-1:0] q_in;

      always_comb begin
         rem2_c = {dv_rem_ff[g-1], dv_lo_ff[g-1][IX]};
         diff_c = rem2_c - {1'b0, dv_a_ff[g-1]};
         ge_c   = (rem2_c >= {1'b0, dv_a_ff[g-1]});
         rem_in = ge_c ? diff_c[AW-1:0] : rem2_c[AW-1:0];
         q_in   = dv_q_ff[g-1];
         q_in[IX] = ge_c;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[g] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[g] <= dv_v_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_hit_ff[g] <= dv_hit_ff[g-1];
            dv_sat_ff[g] <= dv_sat_ff[g-1];
            dv_a_ff[g]   <= dv_a_ff[g-1];
            dv_rem_ff[g] <= rem_in;
            dv_lo_ff[g]  <= dv_lo_ff[g-1];
            dv_q_ff[g]   <= q_in;
         end
      end
   end

   always_comb begin
      if (!dv_hit_ff[QW]) begin
         rsp_dist_in = '0;
      end else if (dv_sat_ff[QW]) begin
         rsp_dist_in = '1;
      end else begin
         rsp_dist_in = dv_q_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_hit_ff  <= dv_hit_ff[QW];
         rsp_dist_ff <= rsp_dist_in;
      end
   end

endmodule

// ===== rtl/ray_sphere_intersect_top.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere intersection top level
// Tests one ray per transaction against the sphere held in the control
// registers and returns the nearest non-negative hit distance.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   ray origin and direction
//   rsp      out        rsp_valid/rsp_ready   hit flag and distance
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// One ray is accepted every clock while the response channel is not
// stalled. From request to response a ray passes seven front stages, the
// queue, an input register and 66 square-root stages, and 35 stages for
// root selection, the divider and the output register. The square-root
// pipeline, one result bit per stage, sets the depth.
// Reset clears all valid flags and loads a unit sphere at the origin.
// A stalled response freezes the back end; the queue then fills and stalls
// the front end.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top #(
   parameter int QUEUE_DEPTH = rsi_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [rsi_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rsi_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_origin_x,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_origin_y,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_origin_z,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_dir_x,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_dir_y,
   input  logic signed [rsi_pkg::COORD_W-1:0]    req_dir_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_hit,
   output logic [rsi_pkg::DIST_W-1:0]            rsp_hit_distance
);

   rsi_pkg::sphere_type  sphere_ff;
   rsi_pkg::ray_job_type front_job, back_job;
   logic                 front_valid, front_ready, back_valid, back_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sphere_ff.center_x <= '0;
         sphere_ff.center_y <= '0;
         sphere_ff.center_z <= '0;
         sphere_ff.radius   <= rsi_pkg::RAD_W'(65536);
      end else if (csr_write_en) begin
         unique case (rsi_pkg::csr_index_type'(csr_index))
            rsi_pkg::CSR_CENTER_X: sphere_ff.center_x <= $signed(csr_wdata);
            rsi_pkg::CSR_CENTER_Y: sphere_ff.center_y <= $signed(csr_wdata);
            rsi_pkg::CSR_CENTER_Z: sphere_ff.center_z <= $signed(csr_wdata);
            rsi_pkg::CSR_RADIUS:   sphere_ff.radius   <= csr_wdata[rsi_pkg::RAD_W-1:0];
            default: ;
         endcase
      end
   end

   rsi_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_dir_x    (req_dir_x),
      .req_dir_y    (req_dir_y),
      .req_dir_z    (req_dir_z),
      .sphere       (sphere_ff),
      .job_valid    (front_valid),
      .job_ready    (front_ready),
      .job          (front_job)
   );

   rsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   rsi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (back_valid),
      .job_ready        (back_ready),
      .job              (back_job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_hit_distance (rsp_hit_distance)
   );

endmodule

// ===== bench/ray_sphere_intersect_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/sphere intersection testbench
// Streams directed and random rays through the intersector under several
// sphere settings. A clocked driver sends rays in random bursts, and a
// monitor stalls the response channel on its own pattern. Each response is
// checked against an exact wide-integer prediction of the hit and distance.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_top_tb;

   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 160;

   typedef struct {
      logic signed [31:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct {
      logic        hit;
      logic [31:0] hit_dist;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [rsi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rsi_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [31:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_hit;
   logic [rsi_pkg::DIST_W-1:0] rsp_hit_distance;

   logic signed [31:0] cen_x = 0, cen_y = 0, cen_z = 0;
   logic [30:0] radius = 31'd65536;

   ray_type ray_queue[$];
   hit_type hit_queue[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0, gap_left = 0;
   int stall_mode = 0, stall_count = 0;

   ray_sphere_intersect_top u_dut (
      .clock(clock), .reset(reset),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z), .req_dir_x(req_dir_x),
      .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_hit_distance(rsp_hit_distance)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [191:0] int_sqrt(input logic [191:0] x);
      logic [191:0] root, bitv;
      root = '0;
      bitv = 192'd1 << 190;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic hit_type predict_hit(input ray_type r);
      logic signed [191:0] ocx, ocy, ocz, dx, dy, dz, rad, a, h, k, disc, s, num, q;
      hit_type res;
      res.hit = 1'b0;
      res.hit_dist = '0;
      ocx = r.ox - cen_x;
      ocy = r.oy - cen_y;
      ocz = r.oz - cen_z;
      dx = r.dx;
      dy = r.dy;
      dz = r.dz;
      rad = {161'd0, radius};
      a = dx * dx + dy * dy + dz * dz;
      if (a == 0) return res;
      h = ocx * dx + ocy * dy + ocz * dz;
      k = ocx * ocx + ocy * ocy + ocz * ocz - rad * rad;
      disc = h * h - a * k;
      if (disc < 0) return res;
      s = int_sqrt(disc);
      if (h <= 0 && k >= 0) num = -h - s;
      else if (h <= 0 || k <= 0) num = -h + s;
      else return res;
      q = (num * 65536) / a;
      res.hit = 1'b1;
      res.hit_dist = (q > 192'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      return res;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      ray_type r;
      logic drive;
      if (!reset) begin
         if (req_valid && req_ready) begin
            r.ox = req_origin_x; r.oy = req_origin_y; r.oz = req_origin_z;
            r.dx = req_dir_x; r.dy = req_dir_y; r.dz = req_dir_z;
            hit_queue.push_back(predict_hit(r));
         end
         if (!req_valid || req_ready) begin
            drive = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (ray_queue.size() > 0) begin
               drive = 1'b1;
               r = ray_queue.pop_front();
               req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
               req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 60);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
            req_valid <= drive;
         end
      end
   end

   // Receiver: checks each response and changes stall behavior when its stall counter wraps.
   always @(posedge clock) begin
      hit_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (hit_queue.size() == 0) begin
               $error("unexpected response transaction");
               errors++;
            end else begin
               e = hit_queue.pop_front();
               if (rsp_hit !== e.hit) begin
                  $error("hit: expected %0d, actual %0d", e.hit, rsp_hit);
                  errors++;
               end
               if (rsp_hit_distance !== e.hit_dist) begin
                  $error("hit_distance: expected %h, actual %h", e.hit_dist,
                         rsp_hit_distance);
                  errors++;
               end
            end
         end
         stall_count++;
         if (stall_count == 200) begin
            stall_count = 0;
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (stall_count % 24) < 6;
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Watchdog on cycles with outstanding work and no transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else if (ray_queue.size() > 0 || hit_queue.size() > 0 || req_valid) begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic add_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz);
      ray_type r;
      r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
      ray_queue.push_back(r);
   endtask

   function automatic logic signed [31:0] rand_span(input int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic add_random_rays(input int count);
      logic signed [31:0] ox, oy, oz;
      int span;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0) begin
            add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            span = 1 << $urandom_range(16, 23);
            ox = cen_x + rand_span(span);
            oy = cen_y + rand_span(span);
            oz = cen_z + rand_span(span);
            add_ray(ox, oy, oz,
                    ((cen_x - ox) >>> $urandom_range(0, 6)) + rand_span(1 << 15),
                    ((cen_y - oy) >>> $urandom_range(0, 6)) + rand_span(1 << 15),
                    ((cen_z - oz) >>> $urandom_range(0, 6)) + rand_span(1 << 15));
         end
      end
   endtask

   task automatic drain();
      while (ray_queue.size() > 0 || req_valid || hit_queue.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_sphere(input logic signed [31:0] x, y, z, input logic [30:0] rad);
      rsi_pkg::csr_index_type idx[4];
      logic [31:0] val[4];
      idx = '{rsi_pkg::CSR_CENTER_X, rsi_pkg::CSR_CENTER_Y, rsi_pkg::CSR_CENTER_Z,
              rsi_pkg::CSR_RADIUS};
      val = '{x, y, z, {1'b0, rad}};
      for (int i = 0; i < 4; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      cen_x = x; cen_y = y; cen_z = z; radius = rad;
      @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_ray(0, 0, -5 * ONE, 0, 0, 0);
      add_ray(0, 0, -5 * ONE, 0, 0, ONE);
      add_ray(0, 0, -5 * ONE, 0, 0, -ONE);
      add_ray(0, 5 * ONE, -5 * ONE, 0, 0, ONE);
      add_ray(0, 0, 0, ONE, 0, 0);
      add_ray(ONE, 0, 0, ONE, 0, 0);
      add_ray(ONE, 0, 0, -ONE, 0, 0);
      add_ray(ONE, 0, -5 * ONE, 0, 0, ONE);
      add_ray(0, 0, 32'sh8000_0000, 0, 0, 1);
      add_ray(0, 0, 32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF);
      add_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      add_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, -1);
      add_ray(-1, -1, -1, -1, -1, -1);
      add_ray(0, 0, 0, 0, 0, 1);
      add_random_rays(150);
      drain();

      set_sphere(rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
                 $urandom_range(1, 20 << 16));
      add_random_rays(170);
      drain();

      set_sphere(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 31'h7FFF_FFFF);
      add_ray(0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      add_random_rays(150);
      drain();

      set_sphere(rand_span(1 << 18), rand_span(1 << 18), rand_span(1 << 18), 0);
      add_ray(cen_x, cen_y, cen_z, ONE, 0, 0);
      add_ray(cen_x - ONE, cen_y, cen_z, ONE, 0, 0);
      add_random_rays(150);
      drain();

      set_sphere($urandom, $urandom, $urandom, $urandom);
      add_random_rays(150);
      drain();

      set_sphere(rand_span(1 << 22), rand_span(1 << 22), rand_span(1 << 22),
                 $urandom_range(1 << 14, 100 << 16));
      add_random_rays(200);
      drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
